@@ hdl/smmt_pkg.sv @@
// Shared types and constants for the segment translator.
package smmt_pkg;

  // Parameter defaults
  localparam int unsigned DEF_SEGMENT_SIZE    = 256;
  localparam int unsigned DEF_SEGMENT_COUNT   = 256;
  localparam int unsigned DEF_PHYS_ADDR_WIDTH = 24;

  // Field widths
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned SIZE_W      = 17;
  localparam int unsigned BASE_W      = 24;
  localparam int unsigned FLAGS_W     = 3;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned PHYS_W      = 24;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam int unsigned ADDR_SPACE = 65536;

  // Flag bit positions
  localparam int unsigned FLAG_RO    = 0;
  localparam int unsigned FLAG_LOCK  = 1;
  localparam int unsigned FLAG_REDIR = 2;

  // Command queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_MAP     = 3'd2,
    REQ_UNMAP   = 3'd3,
    REQ_REDIR   = 3'd4,
    REQ_UNREDIR = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE       = 2'd0,
    STATUS_BLOCKED    = 2'd1,
    STATUS_BAD_REGION = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_MAP     = 3'd2,
    CMD_UNMAP   = 3'd3,
    CMD_REDIR   = 3'd4,
    CMD_UNREDIR = 3'd5,
    CMD_BAD     = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [ADDR_W-1:0]   address;
    logic [SIZE_W-1:0]   region_size;
    logic [BASE_W-1:0]   phys_base;
    logic [FLAGS_W-1:0]  map_flags;
    logic [DATA_W-1:0]   write_data;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic                mem_enable;
    logic                mem_write;
    logic [PHYS_W-1:0]   phys_addr;
    logic [DATA_W-1:0]   mem_data;
    logic                open_bus;
  } res_t;

endpackage

@@ hdl/smmt_front.sv @@
// Front end: takes request beats, checks regions and classifies them into commands.
module smmt_front #(
  parameter int unsigned SEGMENT_SIZE  = smmt_pkg::DEF_SEGMENT_SIZE,
  parameter int unsigned SEGMENT_COUNT = smmt_pkg::DEF_SEGMENT_COUNT
) (
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [smmt_pkg::REQ_W-1:0]        in_tuser_i,
  input  logic [smmt_pkg::IN_TDATA_W-1:0]   in_tdata_i,
  input  logic                              full_i,
  output logic                              push_o,
  output smmt_pkg::cmd_t                    cmd_o
);

  localparam int unsigned SegBits  = $clog2(SEGMENT_SIZE);
  localparam longint unsigned MapBytes = longint'(SEGMENT_SIZE) * longint'(SEGMENT_COUNT);
  localparam longint unsigned Limit =
    (MapBytes > smmt_pkg::ADDR_SPACE) ? smmt_pkg::ADDR_SPACE : MapBytes;
  localparam int unsigned EndBits = smmt_pkg::SIZE_W + 1;

  logic [smmt_pkg::ADDR_W-1:0]  address;
  logic [smmt_pkg::SIZE_W-1:0]  region_size;
  logic [EndBits-1:0]           region_end;
  logic                         region_bad;

  assign address     = in_tdata_i[15:0];
  assign region_size = in_tdata_i[32:16];
  assign region_end  = EndBits'(address) + EndBits'(region_size);

  assign region_bad = (address[SegBits-1:0] != '0) ||
                      (region_size == '0) ||
                      (region_size[SegBits-1:0] != '0) ||
                      (region_end > EndBits'(Limit));

  always_comb begin
    cmd_o             = '0;
    cmd_o.address     = address;
    cmd_o.region_size = region_size;
    cmd_o.phys_base   = in_tdata_i[56:33];
    cmd_o.map_flags   = in_tdata_i[59:57];
    cmd_o.write_data  = in_tdata_i[67:60];
    case (in_tuser_i)
      smmt_pkg::REQ_READ:    cmd_o.kind = smmt_pkg::CMD_READ;
      smmt_pkg::REQ_WRITE:   cmd_o.kind = smmt_pkg::CMD_WRITE;
      smmt_pkg::REQ_MAP:     cmd_o.kind = region_bad ? smmt_pkg::CMD_BAD : smmt_pkg::CMD_MAP;
      smmt_pkg::REQ_UNMAP:   cmd_o.kind = region_bad ? smmt_pkg::CMD_BAD : smmt_pkg::CMD_UNMAP;
      smmt_pkg::REQ_REDIR:   cmd_o.kind = smmt_pkg::CMD_REDIR;
      smmt_pkg::REQ_UNREDIR: cmd_o.kind = smmt_pkg::CMD_UNREDIR;
      default:               cmd_o.kind = smmt_pkg::CMD_NOP;
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

@@ hdl/smmt_fifo.sv @@
// Short command queue between the front end and the back end.
module smmt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smmt_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output smmt_pkg::cmd_t data_o
);

  localparam int unsigned Depth   = smmt_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  smmt_pkg::cmd_t       slots_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CntBits'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/smmt_back.sv @@
// Back end: segment table, region walker and translation of accesses.
module smmt_back #(
  parameter int unsigned SEGMENT_SIZE    = smmt_pkg::DEF_SEGMENT_SIZE,
  parameter int unsigned SEGMENT_COUNT   = smmt_pkg::DEF_SEGMENT_COUNT,
  parameter int unsigned PHYS_ADDR_WIDTH = smmt_pkg::DEF_PHYS_ADDR_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  smmt_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output smmt_pkg::res_t res_o
);

  localparam int unsigned SegBits     = $clog2(SEGMENT_SIZE);
  localparam int unsigned IdxBits     = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
  localparam int unsigned AddrIdxBits = smmt_pkg::ADDR_W - SegBits;
  localparam int unsigned CntBits     = smmt_pkg::SIZE_W - SegBits;
  localparam int unsigned PaW         = PHYS_ADDR_WIDTH;
  localparam int unsigned EntryBits   = smmt_pkg::FLAGS_W + PaW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_WALK = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  smmt_pkg::cmd_t         cmd_q;
  logic [SEGMENT_COUNT-1:0] seg_valid_q;
  logic                   redir0_q;
  logic                   spare_valid_q;
  logic [PaW-1:0]         spare_base_q;
  logic [EntryBits-1:0]   table_mem [SEGMENT_COUNT];
  logic [EntryBits-1:0]   rd_data_q;
  logic [IdxBits-1:0]     walk_idx_q;
  logic [CntBits-1:0]     walk_left_q;
  logic [PaW-1:0]         walk_base_q;
  smmt_pkg::res_t         res_q, res_new;
  logic                   res_valid_q, res_valid_d;
  logic                   produce;
  logic                   pop;

  logic [IdxBits-1:0]     pop_idx;
  logic [31:0]            pop_base32;
  logic [PaW-1:0]         pop_base;

  logic [AddrIdxBits-1:0] acc_idx_full;
  logic                   acc_in_range;
  logic [IdxBits-1:0]     acc_seg;
  logic                   seg_valid_bit;
  logic                   redirected;
  logic                   ent_valid, ent_ro, ent_lock;
  logic [PaW-1:0]         ent_base;
  logic [PaW-1:0]         phys_sum;
  logic [31:0]            phys_sum32;
  logic                   is_write;
  logic                   blocked;
  logic                   walk_map;

  assign pop = (state_q == S_IDLE) && cmd_valid_i && (!res_valid_q || res_ready_i);
  assign cmd_pop_o = pop;

  assign pop_idx    = IdxBits'(cmd_i.address[smmt_pkg::ADDR_W-1:SegBits]);
  assign pop_base32 = 32'(cmd_i.phys_base);
  assign pop_base   = pop_base32[PaW-1:0];

  // Access translation, evaluated from the registered table read in S_READ
  assign acc_idx_full  = cmd_q.address[smmt_pkg::ADDR_W-1:SegBits];
  assign acc_in_range  = (32'(acc_idx_full) < SEGMENT_COUNT);
  assign acc_seg       = IdxBits'(acc_idx_full);
  assign seg_valid_bit = acc_in_range && seg_valid_q[acc_seg];
  // segment 0 keeps its redirect bit apart: it can be set while the segment is unmapped
  assign redirected    = acc_in_range &&
                         ((acc_idx_full == '0) ? redir0_q
                                               : (seg_valid_bit &&
                                                  rd_data_q[PaW + smmt_pkg::FLAG_REDIR]));
  assign ent_valid  = redirected ? spare_valid_q : seg_valid_bit;
  assign ent_ro     = redirected ? 1'b1 : rd_data_q[PaW + smmt_pkg::FLAG_RO];
  assign ent_lock   = redirected ? 1'b0 : rd_data_q[PaW + smmt_pkg::FLAG_LOCK];
  assign ent_base   = redirected ? spare_base_q : rd_data_q[PaW-1:0];
  assign phys_sum   = ent_base + PaW'(cmd_q.address[SegBits-1:0]);
  assign phys_sum32 = 32'(phys_sum);
  assign is_write   = (cmd_q.kind == smmt_pkg::CMD_WRITE);
  assign blocked    = !ent_valid || ent_lock || (is_write && ent_ro);
  assign walk_map   = (cmd_q.kind == smmt_pkg::CMD_MAP);

  always_comb begin
    state_d = state_q;
    produce = 1'b0;
    res_new = '0;
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          case (cmd_i.kind)
            smmt_pkg::CMD_READ,
            smmt_pkg::CMD_WRITE: state_d = S_READ;
            smmt_pkg::CMD_MAP,
            smmt_pkg::CMD_UNMAP: state_d = S_WALK;
            smmt_pkg::CMD_BAD: begin
              produce        = 1'b1;
              res_new.status = smmt_pkg::STATUS_BAD_REGION;
            end
            default: begin
              produce        = 1'b1;
              res_new.status = smmt_pkg::STATUS_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        produce = 1'b1;
        state_d = S_IDLE;
        if (blocked) begin
          res_new.status   = smmt_pkg::STATUS_BLOCKED;
          res_new.open_bus = !is_write;
        end else begin
          res_new.status     = smmt_pkg::STATUS_DONE;
          res_new.mem_enable = 1'b1;
          res_new.mem_write  = is_write;
          res_new.phys_addr  = phys_sum32[smmt_pkg::PHYS_W-1:0];
          res_new.mem_data   = is_write ? cmd_q.write_data : '0;
        end
      end
      S_WALK: begin
        if (walk_left_q == CntBits'(1)) begin
          produce        = 1'b1;
          res_new.status = smmt_pkg::STATUS_DONE;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (produce) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      seg_valid_q   <= '0;
      redir0_q      <= 1'b0;
      spare_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (pop && cmd_i.kind == smmt_pkg::CMD_REDIR) begin
        redir0_q      <= 1'b1;
        spare_valid_q <= 1'b1;
      end
      if (pop && cmd_i.kind == smmt_pkg::CMD_UNREDIR) begin
        redir0_q      <= 1'b0;
        spare_valid_q <= 1'b0;
      end
      if (state_q == S_WALK) begin
        seg_valid_q[walk_idx_q] <= walk_map;
        if (walk_idx_q == '0) begin
          redir0_q <= walk_map && cmd_q.map_flags[smmt_pkg::FLAG_REDIR];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q       <= cmd_i;
      rd_data_q   <= table_mem[pop_idx];
      walk_idx_q  <= pop_idx;
      walk_left_q <= cmd_i.region_size[smmt_pkg::SIZE_W-1:SegBits];
      walk_base_q <= pop_base;
      if (cmd_i.kind == smmt_pkg::CMD_REDIR) begin
        spare_base_q <= pop_base;
      end
    end
    if (state_q == S_WALK) begin
      // one segment per cycle; unmap only needs the valid bit cleared
      if (walk_map) begin
        table_mem[walk_idx_q] <= {cmd_q.map_flags, walk_base_q};
      end
      walk_idx_q  <= walk_idx_q + 1'b1;
      walk_left_q <= walk_left_q - 1'b1;
      walk_base_q <= walk_base_q + PaW'(SEGMENT_SIZE);
    end
    if (produce) begin
      res_q <= res_new;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hdl/segment_mapped_memory_translator.sv @@
// Top level of the segment-mapped memory translator.
//
// Request beats enter on the s_axis channel (kind in tuser, operands in tdata)
// and each produces exactly one result beat on the m_axis channel, in order.
// The result carries a status, the backing-memory enables, the physical
// address and the byte to write; the memory itself sits outside the block.
// SEGMENT_SIZE must be a power of two; the table holds SEGMENT_COUNT entries
// plus one spare entry used by every redirected segment.
// A read or write result passes the queue, then the registered table memory
// read, then the output register; redirect, remove, unknown and rejected
// region requests skip the table read. A map or unmap of N segments walks
// the table one segment per cycle and returns its result once the last
// segment is written. The back end takes no new command until the last one
// has produced its result; the command queue holds 2 beats so the sender
// keeps going while the back end works.
// Reset clears all valid bits and the redirect at once; no clearing pass.
// If the receiver holds m_axis_tready low, the result stays in the output
// register, the back end stops taking commands, and s_axis_tready falls once
// the queue is full.
module segment_mapped_memory_translator #(
  parameter int unsigned SEGMENT_SIZE    = smmt_pkg::DEF_SEGMENT_SIZE,
  parameter int unsigned SEGMENT_COUNT   = smmt_pkg::DEF_SEGMENT_COUNT,
  parameter int unsigned PHYS_ADDR_WIDTH = smmt_pkg::DEF_PHYS_ADDR_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // req_type[2:0]
  input  logic [smmt_pkg::REQ_W-1:0]         s_axis_tuser,
  // address[15:0], region_size[32:16], phys_base[56:33], map_flags[59:57],
  // write_data[67:60], zero[71:68]
  input  logic [smmt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], mem_enable[2], mem_write[3], phys_addr[27:4], mem_data[35:28],
  // open_bus[36], zero[39:37]
  output logic [smmt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic            push, full, pop, cmd_valid;
  smmt_pkg::cmd_t  front_cmd, queue_cmd;
  smmt_pkg::res_t  res;

  smmt_front #(
    .SEGMENT_SIZE  (SEGMENT_SIZE),
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_tuser_i (s_axis_tuser),
    .in_tdata_i (s_axis_tdata),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  smmt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (queue_cmd)
  );

  smmt_back #(
    .SEGMENT_SIZE    (SEGMENT_SIZE),
    .SEGMENT_COUNT   (SEGMENT_COUNT),
    .PHYS_ADDR_WIDTH (PHYS_ADDR_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.open_bus, res.mem_data, res.phys_addr,
                         res.mem_write, res.mem_enable, res.status};

endmodule
